/* sv/length_prefixed_packet_deframer_core_defines.svh */
// Assertion macros for the length-prefixed packet deframer.
// Included by the top level; expects clk and arst_n in scope.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Concurrent check on the core clock, idle while reset is asserted.
`define LPPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that applies only while the result channel holds a valid item.
`define LPPD_ASSERT_OUT(lbl, cond, msg) \
	`LPPD_ASSERT(lbl, m_tvalid |-> (cond), msg)

`endif

/* sv/lppd_pkg.sv */
// Shared types and constants of the length-prefixed packet deframer.
// No dependencies; used by the parser, the result register and the top level.
package lppd_pkg;

	// Default largest payload length that is accepted.
	localparam int MAX_PAYLOAD_DEF = 64;

	// Result kinds.
	localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [1:0] KIND_EMPTY     = 2'd1;
	localparam logic [1:0] KIND_BAD_IDENT = 2'd2;
	localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_IDENT_FIRST  = 1'b0;
	localparam logic CFG_IDENT_SECOND = 1'b1;

	// Header parse phase.
	typedef enum logic [4:0] {
		PH_IDENT = 5'b00001,
		PH_DESC  = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_PAD   = 5'b01000,
		PH_DATA  = 5'b10000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ident;
		logic [7:0] descriptor;
		logic [7:0] pkt_len;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic       last;
	} result_t;

endpackage

/* sv/length_prefixed_packet_deframer_core.sv */
// Length-prefixed packet deframer, top level.
// Channels: s_* carries received bytes in s_tdata[7:0]; m_* carries one
// result item per payload byte, per empty packet and per header error.
// Each header is identifier, descriptor, length and padding byte; the
// identifier must equal one of the two configured values.
// cfg_we/cfg_index/cfg_data write the identifier registers (index 0 and 1);
// the user must write them only while no item is in flight; no logic checks it.
// A byte accepted on s_* passes through the input register, then the result
// register, from which its result can be taken on m_*.
// Throughput: one byte per cycle while m_tready stays high; the parse state
// updates once per byte between the two registers.
// A stalled receiver holds the result register; the input register still
// takes one more byte, after which s_tready drops until the result is taken.
// Reset (arst_n low) empties both registers, restores the identifier
// registers to 0 and 1 and returns the parser to the identifier byte.
// Depends on lppd_pkg, lppd_parser, lppd_out_reg and the defines header.
`include "length_prefixed_packet_deframer_core_defines.svh"

module length_prefixed_packet_deframer_core #(
	parameter int MAX_PAYLOAD = lppd_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// Received bytes.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] ident, [15:8] descriptor,
	                               // [23:16] pkt_len, [31:24] data_byte,
	                               // [39:32] byte_index
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last
);

	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              advance;
	logic              can_load;
	logic              res_valid;
	lppd_pkg::result_t res;
	lppd_pkg::result_t out_res;

	// The input register moves on whenever the result register can take.
	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	// Header parser.
	lppd_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.rx_byte   (rx_byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register.
	lppd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_valid (res_valid),
		.res       (res),
		.m_tready  (m_tready),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_res   (out_res)
	);

	// Output packing.
	assign m_tdata = {out_res.byte_index, out_res.data_byte, out_res.pkt_len,
	                  out_res.descriptor, out_res.ident};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

	// Checks on the block's own logic.
	`LPPD_ASSERT(a_in_hold, valid_s1 && !advance |=> valid_s1 && $stable(rx_byte_s1), "input register lost a byte")
	`LPPD_ASSERT_OUT(a_last_on_status, m_tuser == lppd_pkg::KIND_PAYLOAD || m_tlast, "status result without last")
	`LPPD_ASSERT_OUT(a_data_zero, m_tuser == lppd_pkg::KIND_PAYLOAD || m_tdata[39:24] == 16'd0, "status result with payload data")
	`LPPD_ASSERT_OUT(a_index_range, m_tuser != lppd_pkg::KIND_PAYLOAD || m_tdata[39:32] < m_tdata[23:16], "payload index beyond length")

endmodule

/* sv/lppd_parser.sv */
// Header parser and configuration registers of the packet deframer.
// Depends on lppd_pkg for the phase type, result kinds and result struct.
module lppd_parser #(
	parameter int MAX_PAYLOAD = lppd_pkg::MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output lppd_pkg::result_t res
);

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	logic [7:0]       ident_first_q;
	logic [7:0]       ident_second_q;
	lppd_pkg::phase_t phase_q;
	lppd_pkg::phase_t phase_d;
	logic [7:0]       held_ident_q;
	logic [7:0]       held_desc_q;
	logic [7:0]       held_len_q;
	logic [7:0]       count_q;
	logic [7:0]       count_d;
	logic             fin;

	// Configuration writes; an unknown index cannot occur with one index bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_first_q  <= 8'd0;
			ident_second_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lppd_pkg::CFG_IDENT_FIRST:  ident_first_q  <= cfg_data;
				lppd_pkg::CFG_IDENT_SECOND: ident_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The last payload byte is the one whose index plus one reaches the length.
	assign fin = ({1'b0, count_q} + 9'd1) >= {1'b0, held_len_q};

	// Next phase and the result caused by the current item.
	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			lppd_pkg::PH_IDENT: begin
				if (rx_byte != ident_first_q && rx_byte != ident_second_q) begin
					res_valid  = 1'b1;
					res.kind   = lppd_pkg::KIND_BAD_IDENT;
					res.ident  = rx_byte;
					res.last   = 1'b1;
				end else begin
					phase_d = lppd_pkg::PH_DESC;
				end
			end
			lppd_pkg::PH_DESC: phase_d = lppd_pkg::PH_LEN;
			lppd_pkg::PH_LEN:  phase_d = lppd_pkg::PH_PAD;
			lppd_pkg::PH_PAD: begin
				if (held_len_q == 8'd0) begin
					phase_d        = lppd_pkg::PH_IDENT;
					res_valid      = 1'b1;
					res.kind       = lppd_pkg::KIND_EMPTY;
					res.ident      = held_ident_q;
					res.descriptor = held_desc_q;
					res.last       = 1'b1;
				end else if (held_len_q > MaxLen) begin
					phase_d        = lppd_pkg::PH_IDENT;
					res_valid      = 1'b1;
					res.kind       = lppd_pkg::KIND_TOO_LONG;
					res.ident      = held_ident_q;
					res.descriptor = held_desc_q;
					res.pkt_len    = held_len_q;
					res.last       = 1'b1;
				end else begin
					phase_d = lppd_pkg::PH_DATA;
					count_d = 8'd0;
				end
			end
			lppd_pkg::PH_DATA: begin
				res_valid      = 1'b1;
				res.kind       = lppd_pkg::KIND_PAYLOAD;
				res.ident      = held_ident_q;
				res.descriptor = held_desc_q;
				res.pkt_len    = held_len_q;
				res.data_byte  = rx_byte;
				res.byte_index = count_q;
				res.last       = fin;
				if (fin) begin
					phase_d = lppd_pkg::PH_IDENT;
					count_d = 8'd0;
				end else begin
					count_d = count_q + 8'd1;
				end
			end
			default: phase_d = lppd_pkg::PH_IDENT;
		endcase
	end

	// Parse state advances once per item taken from the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lppd_pkg::PH_IDENT;
			held_ident_q <= 8'd0;
			held_desc_q  <= 8'd0;
			held_len_q   <= 8'd0;
			count_q      <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			if (phase_q == lppd_pkg::PH_IDENT) held_ident_q <= rx_byte;
			if (phase_q == lppd_pkg::PH_DESC)  held_desc_q  <= rx_byte;
			if (phase_q == lppd_pkg::PH_LEN)   held_len_q   <= rx_byte;
		end
	end

endmodule

/* sv/lppd_out_reg.sv */
// Result register of the packet deframer: holds one item until it is taken.
// Depends on lppd_pkg for the result struct.
module lppd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              res_valid,
	input  lppd_pkg::result_t res,
	input  logic              m_tready,
	output logic              can_load,
	output logic              out_valid,
	output lppd_pkg::result_t out_res
);

	logic              valid_q;
	lppd_pkg::result_t res_q;

	// A new result may enter when the register is empty or being emptied.
	assign can_load = !valid_q || m_tready;

	// Valid flag: set by a loaded result, cleared when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
